@@ hdl/kvt_pkg.sv @@
package kvt_pkg;

   // table geometry
   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_ERASE  = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_ABSENT  = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // per-cell controls driven by the sequencer
   typedef struct packed {
      logic valid;      // cell lies below the entry count
      logic compare;    // capture the key match
      logic write_new;  // load the item key and value
      logic shift;      // take the upper neighbor's entry
   } cell_ctrl_type;

endpackage

@@ hdl/kvt_if.sv @@
interface kvt_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          op;
   logic [kvt_pkg::KEY_WIDTH-1:0]       key;
   logic [kvt_pkg::VALUE_WIDTH-1:0]     value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic                                hit;
   logic [kvt_pkg::VALUE_WIDTH-1:0]     found_value;
   logic [kvt_pkg::COUNT_WIDTH-1:0]     entry_count;

   modport source (output valid, output status, output hit, output found_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input hit, input found_value,
                   input entry_count, output ready);
endinterface

@@ hdl/kvt_cell.sv @@
module kvt_cell (
   input  logic                                clock,
   input  kvt_pkg::cell_ctrl_type              ctrl,
   input  logic [kvt_pkg::KEY_WIDTH-1:0]       item_key,
   input  logic [kvt_pkg::VALUE_WIDTH-1:0]     item_value,
   input  logic [kvt_pkg::KEY_WIDTH-1:0]       next_key,
   input  logic [kvt_pkg::VALUE_WIDTH-1:0]     next_value,
   output logic [kvt_pkg::KEY_WIDTH-1:0]       key,
   output logic [kvt_pkg::VALUE_WIDTH-1:0]     value,
   output logic                                match
);

   logic [kvt_pkg::KEY_WIDTH-1:0]   key_ff;
   logic [kvt_pkg::VALUE_WIDTH-1:0] value_ff;
   logic                            match_ff;

   // compare against the item key; only live entries can match
   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         match_ff <= ctrl.valid && (key_ff == item_key);
      end
   end

   // load a new entry or take the neighbor's entry to close a gap
   always_ff @(posedge clock) begin
      if (ctrl.write_new) begin
         key_ff   <= item_key;
         value_ff <= item_value;
      end else if (ctrl.shift) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign match = match_ff;

endmodule

@@ hdl/key_value_table.sv @@
// Key/value table with up to DEPTH unique keys, held in a row of cells.
// Request channel (req_bus): op, key, value; one beat per operation
// (insert, find, erase, clear). Response channel (rsp_bus): status, hit,
// found_value and entry_count; exactly one beat per request, in order.
// Each request is handled in steps: the beat is registered, every cell then
// compares its key in parallel, and a resolve step reduces the match flags,
// updates the cells (append, or shift down above an erased entry) and
// loads the response register. One request is handled at a time.
// The response register decouples the channels: the next request is
// accepted in the cycle the pending response beat is taken. If the
// receiver stalls, the response holds and no further request is accepted.
// Reset clears the entry count and the handshake state; cell contents are
// not cleared, since entries at or above the count are never read.
module key_value_table (
   input  logic              clock,
   input  logic              reset,
   kvt_req_if.sink           req_bus,
   kvt_rsp_if.source         rsp_bus
);

   localparam int D  = kvt_pkg::DEPTH;
   localparam int KW = kvt_pkg::KEY_WIDTH;
   localparam int VW = kvt_pkg::VALUE_WIDTH;
   localparam int CW = kvt_pkg::COUNT_WIDTH;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_RESOLVE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    op_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic [1:0]    status_ff, status_in;
   logic          hit_ff, hit_in;
   logic [VW-1:0] found_ff, found_in;

   logic          accept;
   logic [D-1:0]  match_vec;
   logic [KW-1:0] cell_key [D];
   logic [VW-1:0] cell_value [D];
   kvt_pkg::cell_ctrl_type cell_ctrl [D];
   logic          any_match;
   logic [VW-1:0] match_value;
   logic          do_write, do_shift;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);

   // capture the request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_bus.op;
         key_ff   <= req_bus.key;
         value_ff <= req_bus.value;
      end
   end

   // reduce match flags; keys are unique so at most one cell matches
   always_comb begin
      any_match   = |match_vec;
      match_value = '0;
      for (int i = 0; i < D; i++) begin
         match_value = match_value | (match_vec[i] ? cell_value[i] : '0);
      end
   end

   // decide the operation outcome
   always_comb begin
      status_in = kvt_pkg::STATUS_OK;
      hit_in    = 1'b0;
      found_in  = '0;
      count_in  = count_ff;
      do_write  = 1'b0;
      do_shift  = 1'b0;
      unique case (op_ff)
         kvt_pkg::OP_INSERT: begin
            if (any_match) begin
               status_in = kvt_pkg::STATUS_PRESENT;
            end else if (count_ff == CW'(D)) begin
               status_in = kvt_pkg::STATUS_FULL;
            end else begin
               do_write = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         kvt_pkg::OP_FIND: begin
            if (any_match) begin
               hit_in   = 1'b1;
               found_in = match_value;
            end else begin
               status_in = kvt_pkg::STATUS_ABSENT;
            end
         end
         kvt_pkg::OP_ERASE: begin
            if (any_match) begin
               do_shift = 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = kvt_pkg::STATUS_ABSENT;
            end
         end
         kvt_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // drive the cell controls; erase shifts every cell at or above the match
   always_comb begin
      for (int i = 0; i < D; i++) begin
         cell_ctrl[i].valid     = CW'(i) < count_ff;
         cell_ctrl[i].compare   = (state_ff == S_COMPARE);
         cell_ctrl[i].write_new = (state_ff == S_RESOLVE) && do_write
                                  && (CW'(i) == count_ff);
         cell_ctrl[i].shift     = (state_ff == S_RESOLVE) && do_shift
                                  && |(match_vec & ({D{1'b1}} >> (D - 1 - i)));
      end
   end

   // row of cells; each takes its upper neighbor's entry on a shift
   for (genvar g = 0; g < D; g++) begin : g_cell
      if (g == D - 1) begin : g_last
         kvt_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[g]),
            .item_key   (key_ff),
            .item_value (value_ff),
            .next_key   (cell_key[g]),
            .next_value (cell_value[g]),
            .key        (cell_key[g]),
            .value      (cell_value[g]),
            .match      (match_vec[g])
         );
      end else begin : g_mid
         kvt_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[g]),
            .item_key   (key_ff),
            .item_value (value_ff),
            .next_key   (cell_key[g+1]),
            .next_value (cell_value[g+1]),
            .key        (cell_key[g]),
            .value      (cell_value[g]),
            .match      (match_vec[g])
         );
      end
   end

   // advance the sequencer and the response handshake
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = S_COMPARE;
         S_COMPARE: state_in = S_RESOLVE;
         S_RESOLVE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_RESOLVE) begin
            count_ff <= count_in;
         end
      end
   end

   // load the response payload
   always_ff @(posedge clock) begin
      if (state_ff == S_RESOLVE) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.hit         = hit_ff;
   assign rsp_bus.found_value = found_ff;
   assign rsp_bus.entry_count = count_ff;

endmodule

@@ hdl/kvt_checker.sv @@
module kvt_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic                              rsp_hit,
   input logic [kvt_pkg::VALUE_WIDTH-1:0]   rsp_found_value,
   input logic [kvt_pkg::COUNT_WIDTH-1:0]   rsp_entry_count
);

   // a stalled response beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_hit)
         && $stable(rsp_found_value) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // one request in flight: no second beat right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // every accepted request is answered with a response beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##2 rsp_valid)
      else $error("response missing");

   // a hit is a successful find, a miss shows a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit ? rsp_status == kvt_pkg::STATUS_OK : rsp_found_value == '0))
      else $error("hit and value disagree");

   // the count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= kvt_pkg::COUNT_WIDTH'(kvt_pkg::DEPTH))
      else $error("entry count out of range");

endmodule

bind key_value_table kvt_port_checker u_kvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_hit         (rsp_bus.hit),
   .rsp_found_value (rsp_bus.found_value),
   .rsp_entry_count (rsp_bus.entry_count)
);
